// ----- rtl/acs_pkg.sv -----
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types, register indexes and AES-128 round functions.
// ----------------------------------------------------------------------------
package acs_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int LAST_ROUND  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE    = 2'd2;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic         busy;
        logic         done;
        logic [127:0] result;
    } eng_status_t;

    localparam logic [2047:0] SBOX_TABLE = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [10:0] base;
        base = {x, 3'b000};
        return SBOX_TABLE[11'd2047 - base -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits in bits 8i+7:8i, column-major state
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                t[8*(4*c+j) +: 8] = sbox(s[8*(4*((c+j)%4)+j) +: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] t);
        logic [127:0] s;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[8*(4*c)   +: 8];
            a1 = t[8*(4*c+1) +: 8];
            a2 = t[8*(4*c+2) +: 8];
            a3 = t[8*(4*c+3) +: 8];
            s[8*(4*c)   +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            s[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            s[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            s[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return s;
    endfunction

    function automatic logic [127:0] key_expand(input logic [127:0] rk,
                                                input logic [7:0]   rcon);
        logic [127:0] n;
        logic [31:0]  tmp;
        tmp = {sbox(rk[103:96]), sbox(rk[127:120]), sbox(rk[119:112]),
               sbox(rk[111:104]) ^ rcon};
        n[31:0]   = rk[31:0]   ^ tmp;
        n[63:32]  = rk[63:32]  ^ n[31:0];
        n[95:64]  = rk[95:64]  ^ n[63:32];
        n[127:96] = rk[127:96] ^ n[95:64];
        return n;
    endfunction

endpackage

// ----- rtl/acs_front.sv -----
// ----------------------------------------------------------------------------
// acs_front
// Input side: takes message beats into a short queue for the back end.
// ----------------------------------------------------------------------------
module acs_front #(
    parameter int DEPTH = acs_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  acs_pkg::item_t in_item,
    output logic           q_valid,
    input  logic           q_pop,
    output acs_pkg::item_t q_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    acs_pkg::item_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready = (cnt_reg != CNT_W'(DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid & in_ready;
    assign pop      = q_pop & q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- rtl/acs_aes_core.sv -----
// ----------------------------------------------------------------------------
// acs_aes_core
// Iterative AES-128 encryption, one round and one key expansion per cycle.
// ----------------------------------------------------------------------------
module acs_aes_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 abort,
    input  logic [127:0]         key,
    input  logic [127:0]         blk,
    output acs_pkg::eng_status_t status
);

    logic         busy_reg, busy_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] rk_reg, rk_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [127:0] rk_round;
    logic [127:0] sr;
    logic [127:0] round_out;
    logic         final_round;

    assign final_round = (rnd_reg == 4'(acs_pkg::LAST_ROUND));
    assign rk_round    = acs_pkg::key_expand(rk_reg, rcon_reg);
    assign sr          = acs_pkg::sub_shift(st_reg);
    assign round_out   = (final_round ? sr : acs_pkg::mix_columns(sr)) ^ rk_round;

    assign status.busy   = busy_reg;
    assign status.done   = busy_reg & final_round;
    assign status.result = round_out;

    always_comb
    begin
        busy_next = busy_reg;
        rnd_next  = rnd_reg;
        st_next   = st_reg;
        rk_next   = rk_reg;
        rcon_next = rcon_reg;
        if (abort)
        begin
            busy_next = 1'b0;
        end
        else if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            rnd_next  = 4'd1;
            st_next   = blk ^ key;
            rk_next   = key;
            rcon_next = 8'h01;
        end
        else if (busy_reg)
        begin
            st_next   = round_out;
            rk_next   = rk_round;
            rcon_next = acs_pkg::xtime(rcon_reg);
            rnd_next  = rnd_reg + 1'b1;
            if (final_round)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            rnd_reg  <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        rk_reg   <= rk_next;
        rcon_reg <= rcon_next;
    end

endmodule

// ----- rtl/acs_back.sv -----
// ----------------------------------------------------------------------------
// acs_back
// Keystream bookkeeping, block prefetch and the output register.
// ----------------------------------------------------------------------------
module acs_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [acs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [acs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                q_valid,
    output logic                                q_pop,
    input  acs_pkg::item_t                      q_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          out_data,
    output logic                                out_last
);

    logic [63:0]  key_low_reg, key_high_reg, nonce_reg;
    logic [3:0]   pos_reg, pos_next;
    logic [63:0]  ctr_reg, ctr_next;
    logic [127:0] cur_ks_reg, cur_ks_next;
    logic [127:0] nxt_ks_reg, nxt_ks_next;
    logic         cur_v_reg, cur_v_next;
    logic         nxt_v_reg, nxt_v_next;
    logic [63:0]  eng_ctr_reg;
    logic         out_v_reg, out_v_next;
    logic [7:0]   out_data_reg;
    logic         out_last_reg;
    logic [7:0]   ks_byte;
    logic         pop, abort, eng_start;
    logic [63:0]  start_ctr;
    acs_pkg::eng_status_t eng;

    assign pop       = q_valid & cur_v_reg & (~out_v_reg | out_ready);
    assign q_pop     = pop;
    assign abort     = cfg_we | (pop & q_item.last);
    assign eng_start = ~eng.busy & ~abort & (~cur_v_reg | ~nxt_v_reg);
    assign start_ctr = cur_v_reg ? ctr_reg + 64'd1 : ctr_reg;
    assign ks_byte   = cur_ks_reg[{pos_reg, 3'b000} +: 8];

    assign out_valid = out_v_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    acs_aes_core u_aes (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (eng_start),
        .abort  (abort),
        .key    ({key_high_reg, key_low_reg}),
        .blk    ({start_ctr, nonce_reg}),
        .status (eng)
    );

    always_comb
    begin
        pos_next    = pos_reg;
        ctr_next    = ctr_reg;
        cur_ks_next = cur_ks_reg;
        nxt_ks_next = nxt_ks_reg;
        cur_v_next  = cur_v_reg;
        nxt_v_next  = nxt_v_reg;
        out_v_next  = out_v_reg;
        if (out_ready)
        begin
            out_v_next = 1'b0;
        end
        if (pop)
        begin
            out_v_next = 1'b1;
            if (q_item.last)
            begin
                pos_next   = '0;
                ctr_next   = '0;
                cur_v_next = 1'b0;
                nxt_v_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg == 4'hf)
                begin
                    ctr_next    = ctr_reg + 64'd1;
                    cur_ks_next = nxt_ks_reg;
                    cur_v_next  = nxt_v_reg;
                    nxt_v_next  = 1'b0;
                end
            end
        end
        if (cfg_we)
        begin
            nxt_v_next = 1'b0;
            if (pos_reg == '0)
            begin
                cur_v_next = 1'b0;
            end
        end
        if (eng.done && !abort)
        begin
            if (eng_ctr_reg == ctr_next && !cur_v_next)
            begin
                cur_ks_next = eng.result;
                cur_v_next  = 1'b1;
            end
            else if (eng_ctr_reg == ctr_next + 64'd1 && !nxt_v_next)
            begin
                nxt_ks_next = eng.result;
                nxt_v_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            nonce_reg    <= '0;
            pos_reg      <= '0;
            ctr_reg      <= '0;
            cur_v_reg    <= 1'b0;
            nxt_v_reg    <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            ctr_reg   <= ctr_next;
            cur_v_reg <= cur_v_next;
            nxt_v_reg <= nxt_v_next;
            out_v_reg <= out_v_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    acs_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    acs_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                    acs_pkg::REG_NONCE:    nonce_reg    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_ks_reg <= cur_ks_next;
        nxt_ks_reg <= nxt_ks_next;
        if (eng_start)
        begin
            eng_ctr_reg <= start_ctr;
        end
        if (pop)
        begin
            out_data_reg <= q_item.data ^ ks_byte;
            out_last_reg <= q_item.last;
        end
    end

endmodule

// ----- rtl/aes128_ctr_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// aes128_ctr_stream_cipher
// AES-128 counter-mode byte stream cipher, same path encrypts and decrypts.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one message byte per beat in tdata, tlast ends a message.
//   m_axis returns the byte XOR keystream with tlast copied through.
//   the user writes key_low, key_high and nonce on cfg_we/cfg_index/cfg_data
//   while the stream is idle, not enforced; a write applies at the next block.
// timing
//   a byte passes the input queue and then the output register. a shared
//   iterative AES core does one round a cycle and the next block is
//   prefetched, so within a message one byte per cycle is sustained while
//   neither stream side stalls. the first block of a message, and one after
//   a key or nonce write, waits for the AES core to finish it.
// reset and stall
//   reset clears the counter, byte position and key and nonce registers to zero.
//   a stalled m_axis holds its beat; the input queue keeps taking bytes
//   until it is full, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module aes128_ctr_stream_cipher #(
    parameter int QUEUE_DEPTH = acs_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [acs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [acs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // data_byte
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,   // out_byte
    output logic                             m_axis_tlast
);

    acs_pkg::item_t in_item;
    acs_pkg::item_t q_item;
    logic           q_valid;
    logic           q_pop;

    assign in_item.data = s_axis_tdata;
    assign in_item.last = s_axis_tlast;

    acs_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    acs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// ----- bench/aes128_ctr_stream_cipher_tb.sv -----
// ----------------------------------------------------------------------------
// aes128_ctr_stream_cipher_tb
// Drives message bytes with random idling on both stream sides, predicts each
// output beat with an independent AES-128 counter-mode keystream model and
// compares byte and tlast in order. Key and nonce are changed between phases.
// ----------------------------------------------------------------------------
module aes128_ctr_stream_cipher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [acs_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [acs_pkg::CFG_DATA_W-1:0]      cfg_data;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [7:0]                          s_axis_tdata;   // data_byte
    logic                                s_axis_tlast;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [7:0]                          m_axis_tdata;   // out_byte
    logic                                m_axis_tlast;

    aes128_ctr_stream_cipher u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    localparam int WATCHDOG_LIMIT = 4000;

    // cipher model state
    logic [63:0]  mdl_key_low;
    logic [63:0]  mdl_key_high;
    logic [63:0]  mdl_nonce;
    logic [63:0]  mdl_counter;
    logic [3:0]   mdl_pos;
    logic [127:0] mdl_keystream;

    acs_pkg::item_t expected_beats[$];
    int             mismatches;
    bit             failed;
    bit             idle_on;
    int             stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p = p ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // inverse in gf(2^8) followed by the affine map
    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] b;
        logic [7:0] y;
        r = 8'h01;
        b = x;
        for (int e = 0; e < 8; e++)
        begin
            if (e != 0)
                r = gf_mul(r, b);
            b = gf_mul(b, b);
        end
        if (x == 8'h00)
            r = 8'h00;
        y = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
              ^ {r[3:0], r[7:4]} ^ 8'h63;
        return y;
    endfunction

    function automatic logic [127:0] encrypt_block(input logic [127:0] key,
                                                   input logic [127:0] blk);
        logic [7:0]   rk [0:175];
        logic [7:0]   st [0:15];
        logic [7:0]   tt [0:15];
        logic [7:0]   tmp [0:3];
        logic [7:0]   rc;
        logic [7:0]   f;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 16; i++)
            rk[i] = key[8*i +: 8];
        for (int i = 16; i < 176; i += 4)
        begin
            for (int j = 0; j < 4; j++)
                tmp[j] = rk[i-4+j];
            if ((i % 16) == 0)
            begin
                f = tmp[0];
                tmp[0] = sbox_calc(tmp[1]) ^ rc;
                tmp[1] = sbox_calc(tmp[2]);
                tmp[2] = sbox_calc(tmp[3]);
                tmp[3] = sbox_calc(f);
                rc = gf_mul(rc, 8'h02);
            end
            for (int j = 0; j < 4; j++)
                rk[i+j] = rk[i-16+j] ^ tmp[j];
        end
        for (int i = 0; i < 16; i++)
            st[i] = blk[8*i +: 8] ^ rk[i];
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++)
                    tt[4*c+j] = sbox_calc(st[4*((c+j)%4)+j]);
            for (int c = 0; c < 4; c++)
            begin
                if (r < 10)
                begin
                    st[4*c]   = gf_mul(tt[4*c], 8'h02) ^ gf_mul(tt[4*c+1], 8'h03)
                                ^ tt[4*c+2] ^ tt[4*c+3];
                    st[4*c+1] = tt[4*c] ^ gf_mul(tt[4*c+1], 8'h02)
                                ^ gf_mul(tt[4*c+2], 8'h03) ^ tt[4*c+3];
                    st[4*c+2] = tt[4*c] ^ tt[4*c+1] ^ gf_mul(tt[4*c+2], 8'h02)
                                ^ gf_mul(tt[4*c+3], 8'h03);
                    st[4*c+3] = gf_mul(tt[4*c], 8'h03) ^ tt[4*c+1] ^ tt[4*c+2]
                                ^ gf_mul(tt[4*c+3], 8'h02);
                end
                else
                begin
                    for (int j = 0; j < 4; j++)
                        st[4*c+j] = tt[4*c+j];
                end
            end
            for (int i = 0; i < 16; i++)
                st[i] = st[i] ^ rk[16*r+i];
        end
        for (int i = 0; i < 16; i++)
            res[8*i +: 8] = st[i];
        return res;
    endfunction

    function automatic acs_pkg::item_t cipher_byte(input logic [7:0] d, input logic last);
        acs_pkg::item_t o;
        if (mdl_pos == 4'd0)
            mdl_keystream = encrypt_block({mdl_key_high, mdl_key_low},
                                          {mdl_counter, mdl_nonce});
        o.data = d ^ mdl_keystream[8*mdl_pos +: 8];
        o.last = last;
        mdl_pos = mdl_pos + 4'd1;
        if (mdl_pos == 4'd0)
            mdl_counter = mdl_counter + 64'd1;
        if (last)
        begin
            mdl_counter = '0;
            mdl_pos = '0;
        end
        return o;
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_beats.push_back(cipher_byte(d, last));
        if (idle_on)
        begin
            while ($urandom_range(99) < 34)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic finish_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic [acs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            acs_pkg::REG_KEY_LOW:  mdl_key_low  = val;
            acs_pkg::REG_KEY_HIGH: mdl_key_high = val;
            acs_pkg::REG_NONCE:    mdl_nonce    = val;
            default:      ;
        endcase
    endtask

    task automatic set_cipher(input logic [63:0] kl, input logic [63:0] kh,
                              input logic [63:0] nn);
        write_reg(acs_pkg::REG_KEY_LOW, kl);
        write_reg(acs_pkg::REG_KEY_HIGH, kh);
        write_reg(acs_pkg::REG_NONCE, nn);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    // all-zero key and nonce at reset, extreme bytes, short and two-block messages
    task automatic test_directed();
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h5a, 1'b1);
        send_byte(8'ha5, 1'b1);
        finish_sending();
        drain_results();
        set_cipher('1, '1, '1);
        for (int i = 0; i < 18; i++)
            send_byte(i[0] ? 8'hff : 8'h00, i == 17);
        finish_sending();
        drain_results();
    endtask

    // key write while the stream is idle mid message
    task automatic test_write_mid_block();
        set_cipher(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h0123456789abcdef);
        send_message(5);
        for (int i = 0; i < 7; i++)
            send_byte(8'($urandom_range(255)), 1'b0);
        finish_sending();
        drain_results();
        set_cipher(rand64(), rand64(), rand64());
        for (int i = 0; i < 20; i++)
            send_byte(8'($urandom_range(255)), i == 19);
        finish_sending();
        drain_results();
    endtask

    task automatic test_random(input int n_bytes);
        int sent;
        int len;
        sent = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(9) == 0)
                idle_on = ~idle_on;
            len = ($urandom_range(7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 35);
            send_message(len);
            sent += len;
            if ($urandom_range(5) == 0)
            begin
                finish_sending();
                drain_results();
                case ($urandom_range(2))
                    0: set_cipher(rand64(), rand64(), rand64());
                    1: set_cipher('0, rand64(), '1);
                    default: set_cipher(rand64(), '0, '0);
                endcase
            end
        end
        finish_sending();
        drain_results();
        idle_on = 1'b1;
    endtask

    // output side: random stall and in-order compare
    always @(posedge clk)
    begin
        acs_pkg::item_t want;
        if (rst_n)
        begin
            m_axis_tready <= (!idle_on) || ($urandom_range(99) >= 34);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    failed = 1'b1;
                    if (mismatches < 10)
                        $display("unexpected beat: data %h last %b", m_axis_tdata,
                                 m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (want.data !== m_axis_tdata || want.last !== m_axis_tlast)
                    begin
                        failed = 1'b1;
                        if (mismatches < 10)
                            $display("mismatch: expected %h/%b got %h/%b", want.data,
                                     want.last, m_axis_tdata, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("aes128_ctr_stream_cipher_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        mismatches    = 0;
        failed        = 1'b0;
        idle_on       = 1'b1;
        stall_cycles  = 0;
        mdl_key_low   = '0;
        mdl_key_high  = '0;
        mdl_nonce     = '0;
        mdl_counter   = '0;
        mdl_pos       = '0;
        mdl_keystream = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_write_mid_block();
        test_random(700);
        if (!failed && expected_beats.size() == 0)
            $display("aes128_ctr_stream_cipher_tb: PASS");
        else
            $display("aes128_ctr_stream_cipher_tb: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/acs_pkg.sv
rtl/acs_front.sv
rtl/acs_aes_core.sv
rtl/acs_back.sv
rtl/aes128_ctr_stream_cipher.sv
bench/aes128_ctr_stream_cipher_tb.sv
